### sv/tlik_pkg.sv
// Shared types, constants and helper functions for the two-link IK solver.
`timescale 1ns / 1ps
package tlik_pkg;

  localparam int FRAC_BITS         = 13;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int ATAN_COUNT        = 24;
  localparam int ATAN_IDX_W        = 5;
  localparam int ZSHIFT            = 30 - FRAC_BITS;
  localparam int DIV_Q_W           = 16;
  localparam int SQ_W              = 34;

  localparam longint PI_Q32    = 64'sd13493037705;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint PI_QF     = (PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam longint PI30      = (PI_Q32 + 64'sd2) >>> 2;
  localparam longint PI30_HALF = PI30 / 2;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [18:0] ang_ext_t;
  typedef logic signed [34:0] cord_t;
  typedef logic signed [33:0] wide_t;
  typedef logic signed [17:0] opnd_t;
  typedef logic signed [17:0] step_t;
  typedef logic [16:0]        len_t;

  typedef enum logic [1:0] {
    CFG_TOLERANCE = 2'd0,
    CFG_MAX_ITER  = 2'd1,
    CFG_SING_THR  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_REACHED    = 2'd0,
    ST_STEP_SMALL = 2'd1,
    ST_ITER_LIMIT = 2'd2,
    ST_SINGULAR   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SC_BASE,
    OP_SC_SUM,
    OP_MAC_DET,
    OP_MAC_N0,
    OP_MAC_N1,
    OP_MAC_RES,
    OP_MAC_STEP,
    OP_SQRT_RES,
    OP_SQRT_STEP,
    OP_DIV_0,
    OP_DIV_1,
    OP_UPDATE,
    OP_RESULT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_BASE,
    S_SC_SUM,
    S_MAC_RES,
    S_SQRT_RES,
    S_CHECK,
    S_MAC_DET,
    S_MAC_N0,
    S_MAC_N1,
    S_DIV_0,
    S_DIV_1,
    S_MAC_STEP,
    S_SQRT_STEP,
    S_UPDATE,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic singular;
    logic res_below;
    logic step_below;
    logic iter_at_limit;
  } dp_stat_t;

  // Reduce into [-pi, pi); inputs stay within two turns of the range.
  function automatic angle_t wrap_angle(ang_ext_t a);
    ang_ext_t pi_e;
    ang_ext_t two_pi;
    ang_ext_t r;
    pi_e   = ang_ext_t'(PI_QF);
    two_pi = ang_ext_t'(2 * PI_QF);
    r = a;
    if (r >= pi_e) r = r - two_pi;
    if (r >= pi_e) r = r - two_pi;
    if (r < -pi_e) r = r + two_pi;
    if (r < -pi_e) r = r + two_pi;
    return angle_t'(r);
  endfunction

  function automatic logic [33:0] mag34(wide_t v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  // arctan(2^-i) in Q30
  function automatic cord_t atan_q30(logic [ATAN_IDX_W-1:0] i);
    cord_t v;
    unique case (i)
      5'd0:    v = 35'sd843314857;
      5'd1:    v = 35'sd497837829;
      5'd2:    v = 35'sd263043837;
      5'd3:    v = 35'sd133525159;
      5'd4:    v = 35'sd67021687;
      5'd5:    v = 35'sd33543516;
      5'd6:    v = 35'sd16775851;
      5'd7:    v = 35'sd8388437;
      5'd8:    v = 35'sd4194283;
      5'd9:    v = 35'sd2097149;
      5'd10:   v = 35'sd1048576;
      5'd11:   v = 35'sd524288;
      5'd12:   v = 35'sd262144;
      5'd13:   v = 35'sd131072;
      5'd14:   v = 35'sd65536;
      5'd15:   v = 35'sd32768;
      5'd16:   v = 35'sd16384;
      5'd17:   v = 35'sd8192;
      5'd18:   v = 35'sd4096;
      5'd19:   v = 35'sd2048;
      5'd20:   v = 35'sd1024;
      5'd21:   v = 35'sd512;
      5'd22:   v = 35'sd256;
      5'd23:   v = 35'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/tlik_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, gives sin and cos.
`timescale 1ns / 1ps
module tlik_cordic import tlik_pkg::*; #(
  parameter int STAGES = DEF_CORDIC_STAGES
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  angle_t angle,
  output logic   busy,
  output logic   done,
  output angle_t sin_out,
  output angle_t cos_out
);

  localparam int CNT_W = $clog2(STAGES + 1);
  localparam cord_t PI30_C   = cord_t'(PI30);
  localparam cord_t HALF_C   = cord_t'(PI30_HALF);
  localparam cord_t GAIN_C   = cord_t'(GAIN_Q30);
  localparam cord_t ROUND_C  = cord_t'(1) <<< (ZSHIFT - 1);

  logic [CNT_W-1:0] cnt;
  cord_t x, y, z;
  logic  flip;
  cord_t z_in, dx, dy, atan_v, xf, yf;

  assign z_in   = cord_t'(angle) <<< ZSHIFT;
  assign dx     = y >>> cnt;
  assign dy     = x >>> cnt;
  assign atan_v = atan_q30(ATAN_IDX_W'(cnt));
  assign xf     = flip ? -x : x;
  assign yf     = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(STAGES)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= GAIN_C;
      y   <= '0;
      cnt <= '0;
      // fold the angle into [-pi/2, pi/2] and negate the result afterwards
      if (z_in > HALF_C) begin
        z    <= z_in - PI30_C;
        flip <= 1'b1;
      end else if (z_in < -HALF_C) begin
        z    <= z_in + PI30_C;
        flip <= 1'b1;
      end else begin
        z    <= z_in;
        flip <= 1'b0;
      end
    end else if (busy) begin
      if (cnt == CNT_W'(STAGES)) begin
        cos_out <= angle_t'((xf + ROUND_C) >>> ZSHIFT);
        sin_out <= angle_t'((yf + ROUND_C) >>> ZSHIFT);
      end else begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_v;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_v;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

### sv/tlik_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module tlik_sqrt import tlik_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SQ_W-1:0] radicand,
  output logic            busy,
  output logic            done,
  output len_t            root
);

  logic [SQ_W-1:0] v;
  logic [SQ_W:0]   r;
  logic [SQ_W-1:0] bitm;
  logic [SQ_W:0]   trial;

  assign trial = r + {1'b0, bitm};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      r    <= '0;
      bitm <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy) begin
      if (bitm == '0) begin
        root <= len_t'(r);
      end else begin
        if ({1'b0, v} >= trial) begin
          v <= v - trial[SQ_W-1:0];
          r <= (r >> 1) + {1'b0, bitm};
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
      end
    end
  end

endmodule

### sv/tlik_div.sv
// Restoring divider for the Newton step: |num|/|den| in Q13, capped at 8 rad, signed.
`timescale 1ns / 1ps
module tlik_div import tlik_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  wide_t num,
  input  wide_t den,
  output logic  busy,
  output logic  done,
  output step_t quo
);

  localparam step_t STEP_CAP = step_t'(8 << FRAC_BITS);

  logic [33:0]         un, ud;
  logic                neg;
  logic                first;
  logic [46:0]         rem;
  logic [48:0]         dsr;
  logic [DIV_Q_W-1:0]  q;
  logic [4:0]          cnt;
  logic                capped;

  assign capped = {3'b000, un} >= {ud, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      first <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
      end else if (busy) begin
        first <= 1'b0;
        if ((first && capped) || (!first && cnt == '0)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      un  <= mag34(num);
      ud  <= mag34(den);
      neg <= num[33] ^ den[33];
    end else if (busy) begin
      if (first) begin
        if (capped) begin
          quo <= neg ? -STEP_CAP : STEP_CAP;
        end else begin
          rem <= {un, {FRAC_BITS{1'b0}}};
          dsr <= {ud, 15'b0};
          q   <= '0;
          cnt <= 5'(DIV_Q_W);
        end
      end else if (cnt == '0) begin
        quo <= neg ? -step_t'({2'b00, q}) : step_t'({2'b00, q});
      end else begin
        if ({2'b00, rem} >= dsr) begin
          rem <= rem - dsr[46:0];
          q   <= {q[DIV_Q_W-2:0], 1'b1};
        end else begin
          q   <= {q[DIV_Q_W-2:0], 1'b0};
        end
        dsr <= dsr >> 1;
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

### sv/tlik_datapath.sv
// Datapath: joint and target registers, kinematics, shared multiplier and arithmetic units.
`timescale 1ns / 1ps
module tlik_datapath import tlik_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  angle_t      target_x,
  input  angle_t      target_y,
  input  angle_t      start_angle_base,
  input  angle_t      start_angle_elbow,
  input  logic [10:0] tolerance,
  input  logic [7:0]  max_iterations,
  input  logic [12:0] singular_threshold,
  output angle_t      angle_base,
  output angle_t      angle_elbow,
  output logic [7:0]  iterations_used,
  output logic [14:0] residual,
  output logic [1:0]  status
);

  angle_t tx, ty, q0, q1, nq0, nq1;
  angle_t s0, c0, s01, c01;
  wide_t  det, n0, n1;
  logic [SQ_W-1:0] sqv;
  len_t   res, step_len;
  logic [7:0] iter;

  // kinematics from the latest sin/cos
  logic signed [16:0] p0, p1, d0, d1;
  opnd_t j0, j1, j2, j3, f0, f1;

  assign p0 = 17'(c0) + 17'(c01);
  assign p1 = 17'(s0) + 17'(s01);
  assign j0 = -opnd_t'(p1);
  assign j1 = -opnd_t'(s01);
  assign j2 = opnd_t'(p0);
  assign j3 = opnd_t'(c01);
  assign f0 = opnd_t'(p0) - opnd_t'(tx);
  assign f1 = opnd_t'(p1) - opnd_t'(ty);
  assign d0 = 17'(nq0) - 17'(q0);
  assign d1 = 17'(nq1) - 17'(q1);

  // sin/cos unit
  logic   sc_start, sc_busy, sc_done, sc_sum_sel;
  angle_t sc_angle, sc_sin, sc_cos;

  assign sc_start = (cmd.op == OP_SC_BASE) || (cmd.op == OP_SC_SUM);
  assign sc_angle = (cmd.op == OP_SC_SUM) ?
                    wrap_angle(ang_ext_t'(q0) + ang_ext_t'(q1)) : q0;

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (sc_start),
    .angle   (sc_angle),
    .busy    (sc_busy),
    .done    (sc_done),
    .sin_out (sc_sin),
    .cos_out (sc_cos)
  );

  // square root unit
  logic sq_start, sq_busy, sq_done, sq_step_sel;
  len_t sq_root;

  assign sq_start = (cmd.op == OP_SQRT_RES) || (cmd.op == OP_SQRT_STEP);

  tlik_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sqv),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  // step divider
  logic  dv_start, dv_busy, dv_done, dv_sel;
  step_t dv_quo;

  assign dv_start = (cmd.op == OP_DIV_0) || (cmd.op == OP_DIV_1);

  tlik_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   ((cmd.op == OP_DIV_1) ? n1 : n0),
    .den   (det),
    .busy  (dv_busy),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // shared multiplier: a*b is held in acc while c*d is formed in preg, then the two are added or subtracted
  logic        mac_start, mac_busy;
  logic [1:0]  mac_ph;
  dp_op_t      mac_sel;
  opnd_t       ma, mb;
  logic signed [35:0] preg, acc;
  logic signed [36:0] mac_sum;
  logic        mac_sub;

  assign mac_start = (cmd.op == OP_MAC_DET) || (cmd.op == OP_MAC_N0) ||
                     (cmd.op == OP_MAC_N1) || (cmd.op == OP_MAC_RES) ||
                     (cmd.op == OP_MAC_STEP);
  assign mac_sub   = (mac_sel == OP_MAC_DET) || (mac_sel == OP_MAC_N0) ||
                     (mac_sel == OP_MAC_N1);
  assign mac_sum   = mac_sub ? (37'(acc) - 37'(preg)) : (37'(acc) + 37'(preg));

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (mac_sel)
      OP_MAC_DET: begin
        ma = (mac_ph == 2'd0) ? j0 : j1;
        mb = (mac_ph == 2'd0) ? j3 : j2;
      end
      OP_MAC_N0: begin
        ma = (mac_ph == 2'd0) ? j3 : j1;
        mb = (mac_ph == 2'd0) ? f0 : f1;
      end
      OP_MAC_N1: begin
        ma = (mac_ph == 2'd0) ? j0 : j2;
        mb = (mac_ph == 2'd0) ? f1 : f0;
      end
      OP_MAC_RES: begin
        ma = (mac_ph == 2'd0) ? f0 : f1;
        mb = ma;
      end
      OP_MAC_STEP: begin
        ma = (mac_ph == 2'd0) ? opnd_t'(d0) : opnd_t'(d1);
        mb = ma;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_busy <= 1'b0;
      mac_ph   <= '0;
    end else if (mac_start) begin
      mac_busy <= 1'b1;
      mac_ph   <= '0;
    end else if (mac_busy) begin
      mac_ph <= mac_ph + 1'b1;
      if (mac_ph == 2'd2) mac_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_start) mac_sel <= cmd.op;
    if (mac_busy) begin
      preg <= ma * mb;
      if (mac_ph == 2'd1) acc <= preg;
    end
  end

  // result routing and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (cmd.op == OP_LOAD) begin
      iter <= '0;
    end else if (cmd.op == OP_UPDATE) begin
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sc_start)  sc_sum_sel  <= (cmd.op == OP_SC_SUM);
    if (sq_start)  sq_step_sel <= (cmd.op == OP_SQRT_STEP);
    if (dv_start)  dv_sel      <= (cmd.op == OP_DIV_1);

    if (cmd.op == OP_LOAD) begin
      tx <= target_x;
      ty <= target_y;
      q0 <= wrap_angle(ang_ext_t'(start_angle_base));
      q1 <= wrap_angle(ang_ext_t'(start_angle_elbow));
    end else if (cmd.op == OP_UPDATE) begin
      q0 <= nq0;
      q1 <= nq1;
    end

    if (sc_done) begin
      if (sc_sum_sel) begin
        s01 <= sc_sin;
        c01 <= sc_cos;
      end else begin
        s0 <= sc_sin;
        c0 <= sc_cos;
      end
    end

    if (mac_busy && mac_ph == 2'd2) begin
      unique case (mac_sel)
        OP_MAC_DET: det <= wide_t'(mac_sum);
        OP_MAC_N0:  n0  <= wide_t'(mac_sum);
        OP_MAC_N1:  n1  <= wide_t'(mac_sum);
        default:    sqv <= mac_sum[SQ_W-1:0];
      endcase
    end

    if (sq_done) begin
      if (sq_step_sel) step_len <= sq_root;
      else             res      <= sq_root;
    end

    if (dv_done) begin
      if (dv_sel) nq1 <= wrap_angle(ang_ext_t'(q1) - ang_ext_t'(dv_quo));
      else        nq0 <= wrap_angle(ang_ext_t'(q0) - ang_ext_t'(dv_quo));
    end

    if (cmd.op == OP_RESULT) begin
      angle_base      <= q0;
      angle_elbow     <= q1;
      iterations_used <= iter;
      residual        <= (res > len_t'(15'h7FFF)) ? 15'h7FFF : res[14:0];
      status          <= cmd.code;
    end
  end

  assign stat.busy = sc_busy | sc_done | sq_busy | sq_done | dv_busy | dv_done | mac_busy;
  assign stat.singular = (det == '0) ||
                         (mag34(det) < (34'(singular_threshold) << FRAC_BITS));
  assign stat.res_below     = res < len_t'(tolerance);
  assign stat.step_below    = step_len < len_t'(tolerance);
  assign stat.iter_at_limit = iter >= max_iterations;

endmodule

### sv/tlik_ctrl.sv
// Controller: sequences the Newton loop and runs the input and output handshakes.
`timescale 1ns / 1ps
module tlik_ctrl import tlik_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  ctrl_state_t state, state_next;
  logic        issued, issued_next;
  logic        stepped, stepped_next;
  status_t     code, code_next;
  logic        out_valid_next;
  logic        work_done;

  assign in_stall  = (state != S_IDLE);
  assign work_done = issued && !stat.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      stepped   <= 1'b0;
      code      <= ST_REACHED;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      issued    <= issued_next;
      stepped   <= stepped_next;
      code      <= code_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    stepped_next   = stepped;
    code_next      = code;
    out_valid_next = out_valid;
    cmd.op         = OP_NONE;
    cmd.code       = code;
    // each work state issues its operation once, then waits for the units to settle
    issued_next    = issued ? !work_done :
                     !(state == S_IDLE || state == S_CHECK || state == S_EMIT);

    // drop the word once the receiver takes it
    if (out_valid && !out_stall) out_valid_next = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op       = OP_LOAD;
          stepped_next = 1'b0;
          state_next   = S_SC_BASE;
        end
      end
      S_SC_BASE: begin
        if (!issued) cmd.op = OP_SC_BASE;
        if (work_done) state_next = S_SC_SUM;
      end
      S_SC_SUM: begin
        if (!issued) cmd.op = OP_SC_SUM;
        if (work_done) state_next = S_MAC_RES;
      end
      S_MAC_RES: begin
        if (!issued) cmd.op = OP_MAC_RES;
        if (work_done) state_next = S_SQRT_RES;
      end
      S_SQRT_RES: begin
        if (!issued) cmd.op = OP_SQRT_RES;
        if (work_done) begin
          priority if (stepped && stat.res_below) begin
            code_next  = ST_REACHED;
            state_next = S_EMIT;
          end else if (stepped && stat.step_below) begin
            code_next  = ST_STEP_SMALL;
            state_next = S_EMIT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.iter_at_limit) begin
          code_next  = ST_ITER_LIMIT;
          state_next = S_EMIT;
        end else begin
          state_next = S_MAC_DET;
        end
      end
      S_MAC_DET: begin
        if (!issued) cmd.op = OP_MAC_DET;
        if (work_done) begin
          if (stat.singular) begin
            code_next  = ST_SINGULAR;
            state_next = S_EMIT;
          end else begin
            state_next = S_MAC_N0;
          end
        end
      end
      S_MAC_N0: begin
        if (!issued) cmd.op = OP_MAC_N0;
        if (work_done) state_next = S_MAC_N1;
      end
      S_MAC_N1: begin
        if (!issued) cmd.op = OP_MAC_N1;
        if (work_done) state_next = S_DIV_0;
      end
      S_DIV_0: begin
        if (!issued) cmd.op = OP_DIV_0;
        if (work_done) state_next = S_DIV_1;
      end
      S_DIV_1: begin
        if (!issued) cmd.op = OP_DIV_1;
        if (work_done) state_next = S_MAC_STEP;
      end
      S_MAC_STEP: begin
        if (!issued) cmd.op = OP_MAC_STEP;
        if (work_done) state_next = S_SQRT_STEP;
      end
      S_SQRT_STEP: begin
        if (!issued) cmd.op = OP_SQRT_STEP;
        if (work_done) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (!issued) begin
          cmd.op       = OP_UPDATE;
          stepped_next = 1'b1;
        end
        if (work_done) state_next = S_SC_BASE;
      end
      S_EMIT: begin
        // hold the result until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_RESULT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### sv/two_link_newton_inverse_kinematics.sv
// Top level of the two-link Newton inverse kinematics solver.
//
// Input channel: in_valid/in_stall with target_x, target_y, start_angle_base and
// start_angle_elbow (Q2.13). A word is taken when in_valid is high and in_stall low;
// in_stall stays high from then until the solve has moved its result to the output
// register. Output channel: out_valid/out_stall with the wrapped angles,
// iterations_used, residual (saturated) and status. The output register holds its
// word while out_stall is high; a new request is taken meanwhile, and a finished
// solve waits in its last state until the register frees up.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 tolerance, 1 max_iterations,
// 2 singular_threshold) and cfg_data; cfg_ready is always high, other indexes are ignored.
// Sequencing: each Newton step runs one CORDIC pass for the base angle and one for
// the joint sum, a shared 18x18 multiplier, a bit-serial root and a bit-serial
// divider, all one after another. One request is in flight at a time.
// Reset: synchronous rst clears the controller, output valid and iteration count and
// loads the register defaults (tolerance 8, limit 64, singular threshold 8).
`timescale 1ns / 1ps
module two_link_newton_inverse_kinematics import tlik_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  angle_t      target_x,
  input  angle_t      target_y,
  input  angle_t      start_angle_base,
  input  angle_t      start_angle_elbow,
  output logic        out_valid,
  input  logic        out_stall,
  output angle_t      angle_base,
  output angle_t      angle_elbow,
  output logic [7:0]  iterations_used,
  output logic [14:0] residual,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [10:0] tolerance;
  logic [7:0]  max_iterations;
  logic [12:0] singular_threshold;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance          <= 11'd8;
      max_iterations     <= 8'd64;
      singular_threshold <= 13'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TOLERANCE: tolerance          <= cfg_data[10:0];
        CFG_MAX_ITER:  max_iterations     <= cfg_data[7:0];
        CFG_SING_THR:  singular_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  tlik_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  tlik_datapath #(.CORDIC_STAGES(CORDIC_STAGES)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .target_x           (target_x),
    .target_y           (target_y),
    .start_angle_base   (start_angle_base),
    .start_angle_elbow  (start_angle_elbow),
    .tolerance          (tolerance),
    .max_iterations     (max_iterations),
    .singular_threshold (singular_threshold),
    .angle_base         (angle_base),
    .angle_elbow        (angle_elbow),
    .iterations_used    (iterations_used),
    .residual           (residual),
    .status             (status)
  );

endmodule

### sv/tlik_checker.sv
// Port-level checks for the IK solver, bound to the top level.
`timescale 1ns / 1ps
module tlik_checker import tlik_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input angle_t      angle_base,
  input angle_t      angle_elbow,
  input logic [7:0]  iterations_used,
  input logic [1:0]  status
);

  localparam angle_t PI_C = angle_t'(PI_QF);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle_base) && $stable(status))
    else $error("output word changed while stalled");

  // one request at a time: the input closes right after a word is taken
  a_in_close: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input still open after accepting a word");

  // convergence is only reported after at least one step
  a_conv_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_REACHED || status == ST_STEP_SMALL) |-> iterations_used != 8'd0)
    else $error("convergence reported without a step");

  a_wrapped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle_base >= -PI_C && angle_base < PI_C &&
                  angle_elbow >= -PI_C && angle_elbow < PI_C)
    else $error("output angle outside [-pi, pi)");

endmodule

bind two_link_newton_inverse_kinematics tlik_checker u_tlik_checker (.*);
